// ===== rtl/core/mpts_pkg.sv =====
// ----------------------------------------------------------------------------
// mpts_pkg: shared types and constants of the multi-policy tick scheduler
// Slot and ring sizing, action and policy codes, ring index arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package mpts_pkg;

  localparam int MAX_PROCS = 16;
  localparam int RING_CAP  = MAX_PROCS + 1;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int POS_W     = $clog2(RING_CAP);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam logic [7:0]  AGE_LIMIT = 8'd20;
  localparam logic [7:0]  AGE_SAT   = 8'd255;
  localparam logic [15:0] SAT16     = 16'hFFFF;
  localparam logic [19:0] SAT20     = 20'hFFFFF;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam logic [2:0] MODE_FCFS  = 3'd0;
  localparam logic [2:0] MODE_SJF   = 3'd1;
  localparam logic [2:0] MODE_PRIO  = 3'd2;
  localparam logic [2:0] MODE_RR    = 3'd3;
  localparam logic [2:0] MODE_PSJF  = 3'd4;
  localparam logic [2:0] MODE_PPRIO = 3'd5;

  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_QUANTUM = 2'd1;
  localparam logic [1:0] REG_AGING   = 2'd2;
  localparam logic [1:0] REG_PCOUNT  = 2'd3;

  // control from the sequencer to the totals accumulator
  typedef struct packed {
    logic clear;
    logic en;
  } acc_ctrl_t;

  // (a + b) mod m for a < m, b <= m
  function automatic logic [POS_W-1:0] ring_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b,
                                                input logic [POS_W-1:0] m);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mpts_if.sv =====
// ----------------------------------------------------------------------------
// mpts_if: valid/ready channels of the scheduler
// Input channel carries load/tick/restart items, output channel tick results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] slot;
  logic [3:0] cpu_burst;
  logic [3:0] io_burst;
  logic [3:0] cycle_count;
  logic [7:0] arrival_time;
  logic [3:0] priority_level;

  modport source (output valid, action, slot, cpu_burst, io_burst, cycle_count,
                  arrival_time, priority_level, input ready);
  modport sink (input valid, action, slot, cpu_burst, io_burst, cycle_count,
                arrival_time, priority_level, output ready);
endinterface

interface mpts_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tick_time;
  logic        running_valid;
  logic [3:0]  running_slot;
  logic        io_valid;
  logic [3:0]  io_slot;
  logic [4:0]  finished_count;
  logic        all_done;
  logic [19:0] total_turnaround;
  logic [19:0] total_wait;
  logic [15:0] idle_ticks;

  modport source (output valid, tick_time, running_valid, running_slot, io_valid, io_slot,
                  finished_count, all_done, total_turnaround, total_wait, idle_ticks,
                  input ready);
  modport sink (input valid, tick_time, running_valid, running_slot, io_valid, io_slot,
                finished_count, all_done, total_turnaround, total_wait, idle_ticks,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mpts_acc.sv =====
// ----------------------------------------------------------------------------
// mpts_acc: turnaround and wait totals
// Adds one slot's turnaround term and wait count per cycle while enabled, saturating.
// ----------------------------------------------------------------------------
`default_nettype none

module mpts_acc
  import mpts_pkg::*;
(
  input  wire logic        clk,
  input  wire acc_ctrl_t   ctrl,
  input  wire logic [15:0] ta,
  input  wire logic [7:0]  arr,
  input  wire logic [15:0] wt,
  output logic [19:0]      tsum,
  output logic [19:0]      wsum
);

  logic [16:0] ta1;
  logic [16:0] term;
  logic [20:0] tadd;
  logic [20:0] wadd;

  always_comb begin
    ta1  = {1'b0, ta} + 17'd1;
    term = (ta1 > {9'd0, arr}) ? (ta1 - {9'd0, arr}) : 17'd0;
    tadd = {1'b0, tsum} + {4'd0, term};
    wadd = {1'b0, wsum} + {5'd0, wt};
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      tsum <= '0;
      wsum <= '0;
    end else if (ctrl.en) begin
      tsum <= (tadd > {1'b0, SAT20}) ? SAT20 : tadd[19:0];
      wsum <= (wadd > {1'b0, SAT20}) ? SAT20 : wadd[19:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/multi_policy_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_policy_tick_scheduler: one CPU, one I/O device, ready and waiting rings
// Load writes a slot, restart clears the run state, a tick runs
// the arrival, selection, CPU, I/O, wait and accounting passes in sequence.
// Sequencing: load, restart and unknown actions are handled in S_IDLE. A tick
//   runs arrival, pick, wait and accounting passes, one slot or ring position
//   per cycle, plus the pick head, swap, dispatch, preempt, CPU and I/O steps.
//   FCFS and round robin skip the pick and preempt steps; a tick after every
//   slot has finished runs only the accounting pass. A result still waiting in
//   the output register holds the sequencer. One item at a time.
// Reset: synchronous; config registers go to their defaults, the run state is
//   cleared without copying the loaded fields, rings empty, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_policy_tick_scheduler
  import mpts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  mpts_in_if.sink          in_ch,
  mpts_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_ARRIVE    = 13'b0000000000010,
    S_PICK_HEAD = 13'b0000000000100,
    S_PICK_SCAN = 13'b0000000001000,
    S_PICK_SWAP = 13'b0000000010000,
    S_DISPATCH  = 13'b0000000100000,
    S_PRE_H     = 13'b0000001000000,
    S_PRE_CMP   = 13'b0000010000000,
    S_CPU_RUN   = 13'b0000100000000,
    S_IO_RUN    = 13'b0001000000000,
    S_WAIT_SCAN = 13'b0010000000000,
    S_SLOT_SCAN = 13'b0100000000000,
    S_DONE      = 13'b1000000000000
  } state_t;

  // configuration
  logic [2:0] policy_mode;
  logic [7:0] slice_ticks;
  logic       aging_enable;
  logic [4:0] process_count;

  // static slot parameters, written by loads
  logic [3:0] s_cpu   [MAX_PROCS];
  logic [3:0] s_io    [MAX_PROCS];
  logic [3:0] s_cyc   [MAX_PROCS];
  logic [7:0] s_arr   [MAX_PROCS];
  logic [3:0] s_prio0 [MAX_PROCS];

  // run fields per slot
  logic [3:0]  prio     [MAX_PROCS];
  logic [3:0]  cur_cpu  [MAX_PROCS];
  logic [3:0]  cur_io   [MAX_PROCS];
  logic [3:0]  cur_cyc  [MAX_PROCS];
  logic [7:0]  tq       [MAX_PROCS];
  logic [7:0]  age      [MAX_PROCS];
  logic [15:0] ta       [MAX_PROCS];
  logic [15:0] wt       [MAX_PROCS];
  logic        fin      [MAX_PROCS];
  logic        arrived  [MAX_PROCS];

  // rings
  logic [SLOT_W-1:0] ready_ring   [RING_CAP];
  logic [SLOT_W-1:0] waiting_ring [RING_CAP];
  logic [POS_W-1:0]  rhead, rcount, whead, wcount;

  // holders and counters
  logic              cpu_valid, io_valid_r;
  logic [SLOT_W-1:0] cpu_slot, io_slot_r;
  logic [15:0]       run_time, idle_total, tick_stamp;
  logic [CNT_W-1:0]  fin_count, n_run;

  // sequencer
  state_t            state;
  logic [POS_W-1:0]  idx;
  logic              active;
  logic [POS_W-1:0]  best_pos;
  logic [SLOT_W-1:0] best_slot, head_slot, h_slot;
  logic [3:0]        best_key, h_key;
  logic              ran_valid;
  logic [SLOT_W-1:0] ran_slot;

  // result register
  logic        out_valid;
  logic [15:0] o_tick;
  logic        o_run_v, o_io_v, o_done;
  logic [3:0]  o_run_s, o_io_s;
  logic [4:0]  o_fin;
  logic [15:0] o_idle;
  logic [19:0] o_tsum, o_wsum;

  logic [19:0] tsum, wsum;
  acc_ctrl_t   acc_ctrl;

  // combinational helpers
  logic              in_acc, restart_go, load_go, tick_go;
  logic [2:0]        md;
  logic [7:0]        quantum;
  logic              is_rr, by_prio, preempt, pick_mode;
  logic [POS_W-1:0]  m, r_tail, r_next, w_tail, w_next;
  logic [POS_W-1:0]  rr_addr;
  logic [SLOT_W-1:0] rr_data, sidx;
  logic              idx_in_ring;
  logic [3:0]        f_cpu, f_io, f_cur_cpu, f_cur_io, f_cur_cyc, f_prio, key;
  logic [7:0]        f_tq, f_age;
  logic [15:0]       f_ta, f_wt, ta_new;
  logic              f_fin;
  logic [CNT_W-1:0]  n_clamp;
  logic              out_load;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign restart_go  = in_acc && (in_ch.action == ACT_RESTART);
  assign load_go     = in_acc && (in_ch.action == ACT_LOAD);
  assign tick_go     = in_acc && (in_ch.action == ACT_TICK);

  always_comb begin
    md        = (policy_mode > MODE_PPRIO) ? MODE_FCFS : policy_mode;
    quantum   = (slice_ticks == 8'd0) ? 8'd1 : slice_ticks;
    is_rr     = (md == MODE_RR);
    by_prio   = (md == MODE_PRIO) || (md == MODE_PPRIO);
    preempt   = (md == MODE_PSJF) || (md == MODE_PPRIO);
    pick_mode = (md == MODE_SJF) || by_prio || (md == MODE_PSJF);
    m         = POS_W'(n_run) + POS_W'(1);
    r_tail    = ring_add(rhead, rcount, m);
    r_next    = ring_add(rhead, POS_W'(1), m);
    w_tail    = ring_add(whead, wcount, m);
    w_next    = ring_add(whead, POS_W'(1), m);
    if (process_count == 5'd0) begin
      n_clamp = CNT_W'(1);
    end else if (process_count > 5'(MAX_PROCS)) begin
      n_clamp = CNT_W'(MAX_PROCS);
    end else begin
      n_clamp = CNT_W'(process_count);
    end
  end

  // one read port on the ready ring
  always_comb begin
    case (state)
      S_PICK_SCAN, S_WAIT_SCAN: rr_addr = idx;
      default:                  rr_addr = rhead;
    endcase
    rr_data     = ready_ring[rr_addr];
    idx_in_ring = ring_add(idx, m - rhead, m) < rcount;
  end

  // one slot-table index per cycle
  always_comb begin
    case (state)
      S_ARRIVE, S_SLOT_SCAN:                       sidx = idx[SLOT_W-1:0];
      S_PICK_HEAD, S_PICK_SCAN, S_PRE_H, S_WAIT_SCAN: sidx = rr_data;
      S_PRE_CMP, S_CPU_RUN:                        sidx = cpu_slot;
      S_IO_RUN:                                    sidx = io_slot_r;
      default:                                     sidx = '0;
    endcase
    f_cpu     = s_cpu[sidx];
    f_io      = s_io[sidx];
    f_cur_cpu = cur_cpu[sidx];
    f_cur_io  = cur_io[sidx];
    f_cur_cyc = cur_cyc[sidx];
    f_prio    = prio[sidx];
    f_tq      = tq[sidx];
    f_age     = age[sidx];
    f_ta      = ta[sidx];
    f_wt      = wt[sidx];
    f_fin     = fin[sidx];
    key       = by_prio ? f_prio : f_cpu;
    ta_new    = (active && !f_fin && (f_ta != SAT16)) ? (f_ta + 16'd1) : f_ta;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode   <= MODE_FCFS;
      slice_ticks   <= 8'd2;
      aging_enable  <= 1'b0;
      process_count <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLICY:  policy_mode   <= cfg_data[2:0];
        REG_QUANTUM: slice_ticks   <= cfg_data;
        REG_AGING:   aging_enable  <= cfg_data[0];
        REG_PCOUNT:  process_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // load: static fields only, zero CPU bursts and cycle counts become one
  always_ff @(posedge clk) begin
    if (load_go) begin
      s_cpu[in_ch.slot]   <= (in_ch.cpu_burst == 4'd0) ? 4'd1 : in_ch.cpu_burst;
      s_io[in_ch.slot]    <= in_ch.io_burst;
      s_cyc[in_ch.slot]   <= (in_ch.cycle_count == 4'd0) ? 4'd1 : in_ch.cycle_count;
      s_arr[in_ch.slot]   <= in_ch.arrival_time;
      s_prio0[in_ch.slot] <= in_ch.priority_level;
    end
  end

  // sequencer and run state
  always_ff @(posedge clk) begin
    logic [3:0] cc, cyc_n;
    logic [7:0] tqn;
    logic       io_free;
    cc      = (f_cur_cpu != 4'd0) ? (f_cur_cpu - 4'd1) : 4'd0;
    tqn     = (is_rr && f_tq != 8'd0) ? (f_tq - 8'd1) : f_tq;
    cyc_n   = f_cur_cyc;
    io_free = 1'b0;
    if (rst || restart_go) begin
      // restart: copy static fields into the run fields of every slot
      for (int i = 0; i < MAX_PROCS; i++) begin
        prio[i]    <= rst ? 4'd0 : s_prio0[i];
        cur_cpu[i] <= rst ? 4'd0 : s_cpu[i];
        cur_io[i]  <= rst ? 4'd0 : s_io[i];
        cur_cyc[i] <= rst ? 4'd0 : s_cyc[i];
        tq[i]      <= rst ? 8'd2 : quantum;
        age[i]     <= '0;
        ta[i]      <= '0;
        wt[i]      <= '0;
        fin[i]     <= 1'b0;
        arrived[i] <= 1'b0;
      end
      for (int p = 0; p < RING_CAP; p++) begin
        ready_ring[p]   <= '0;
        waiting_ring[p] <= '0;
      end
      rhead      <= '0;
      rcount     <= '0;
      whead      <= '0;
      wcount     <= '0;
      cpu_valid  <= 1'b0;
      io_valid_r <= 1'b0;
      cpu_slot   <= '0;
      io_slot_r  <= '0;
      run_time   <= '0;
      idle_total <= '0;
      fin_count  <= '0;
      n_run      <= rst ? CNT_W'(1) : n_clamp;
      state      <= S_IDLE;
      idx        <= '0;
      active     <= 1'b0;
      ran_valid  <= 1'b0;
      ran_slot   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (tick_go) begin
            tick_stamp <= run_time;
            ran_valid  <= 1'b0;
            ran_slot   <= '0;
            idx        <= '0;
            if (fin_count == n_run) begin
              active <= 1'b0;
              state  <= S_SLOT_SCAN;
            end else begin
              active <= 1'b1;
              state  <= S_ARRIVE;
            end
          end
        end

        S_ARRIVE: begin
          if (!arrived[sidx] && ({8'd0, s_arr[sidx]} == run_time)) begin
            arrived[sidx] <= 1'b1;
            if (rcount < m) begin
              ready_ring[r_tail] <= sidx;
              rcount             <= rcount + POS_W'(1);
            end
          end
          idx <= idx + POS_W'(1);
          if (idx == POS_W'(n_run - CNT_W'(1))) begin
            state <= pick_mode ? S_PICK_HEAD : S_DISPATCH;
          end
        end

        S_PICK_HEAD: begin
          if (rcount == '0) begin
            state <= S_DISPATCH;
          end else begin
            head_slot <= rr_data;
            best_slot <= rr_data;
            best_pos  <= rhead;
            best_key  <= key;
            idx       <= '0;
            state     <= S_PICK_SCAN;
          end
        end

        S_PICK_SCAN: begin
          // strict less: ties keep the head, then the lowest position
          if (idx_in_ring && key < best_key) begin
            best_pos  <= idx;
            best_slot <= rr_data;
            best_key  <= key;
          end
          idx <= idx + POS_W'(1);
          if (idx == POS_W'(n_run)) begin
            state <= S_PICK_SWAP;
          end
        end

        S_PICK_SWAP: begin
          if (best_pos != rhead) begin
            ready_ring[rhead]    <= best_slot;
            ready_ring[best_pos] <= head_slot;
          end
          state <= S_DISPATCH;
        end

        S_DISPATCH: begin
          if (cpu_valid) begin
            state <= (preempt && rcount != '0) ? S_PRE_H : S_CPU_RUN;
          end else if (rcount != '0) begin
            cpu_slot  <= rr_data;
            cpu_valid <= 1'b1;
            rhead     <= r_next;
            rcount    <= rcount - POS_W'(1);
            state     <= S_CPU_RUN;
          end else begin
            if (idle_total != SAT16) begin
              idle_total <= idle_total + 16'd1;
            end
            state <= S_IO_RUN;
          end
        end

        S_PRE_H: begin
          h_slot <= rr_data;
          h_key  <= (md == MODE_PSJF) ? f_cur_cpu : f_prio;
          state  <= S_PRE_CMP;
        end

        S_PRE_CMP: begin
          // swap the holder into the head when the head wins
          if (h_key < ((md == MODE_PSJF) ? f_cur_cpu : f_prio)) begin
            ready_ring[rhead] <= cpu_slot;
            cpu_slot          <= h_slot;
          end
          state <= S_CPU_RUN;
        end

        S_CPU_RUN: begin
          ran_valid <= 1'b1;
          ran_slot  <= cpu_slot;
          if (cc == 4'd0) begin
            if (f_cur_io == 4'd0) begin
              cyc_n          = (f_cur_cyc != 4'd0) ? (f_cur_cyc - 4'd1) : 4'd0;
              cur_cpu[sidx]  <= f_cpu;
              cur_io[sidx]   <= f_io;
              tq[sidx]       <= quantum;
            end else begin
              cur_cpu[sidx]  <= 4'd0;
              tq[sidx]       <= tqn;
            end
            cur_cyc[sidx] <= cyc_n;
            if (cyc_n == 4'd0) begin
              fin[sidx] <= 1'b1;
              fin_count <= fin_count + CNT_W'(1);
            end else if (f_io == 4'd0) begin
              if (rcount < m) begin
                ready_ring[r_tail] <= sidx;
                rcount             <= rcount + POS_W'(1);
              end
            end else if (wcount < m) begin
              waiting_ring[w_tail] <= sidx;
              wcount               <= wcount + POS_W'(1);
            end
            cpu_valid <= 1'b0;
          end else if (is_rr && tqn == 8'd0) begin
            // slice over: rotate only when someone is waiting
            cur_cpu[sidx] <= cc;
            tq[sidx]      <= quantum;
            if (rcount != '0) begin
              ready_ring[r_tail] <= sidx;
              cpu_slot           <= rr_data;
              rhead              <= r_next;
            end
          end else begin
            cur_cpu[sidx] <= cc;
            tq[sidx]      <= tqn;
          end
          state <= S_IO_RUN;
        end

        S_IO_RUN: begin
          if (io_valid_r) begin
            if (f_cur_io <= 4'd1) begin
              if (f_cur_cpu == 4'd0) begin
                cyc_n         = (f_cur_cyc != 4'd0) ? (f_cur_cyc - 4'd1) : 4'd0;
                cur_cpu[sidx] <= f_cpu;
                cur_io[sidx]  <= f_io;
                tq[sidx]      <= quantum;
              end else begin
                cur_io[sidx]  <= 4'd0;
              end
              cur_cyc[sidx] <= cyc_n;
              if (cyc_n == 4'd0) begin
                fin[sidx] <= 1'b1;
                fin_count <= fin_count + CNT_W'(1);
              end else if (rcount < m) begin
                ready_ring[r_tail] <= sidx;
                rcount             <= rcount + POS_W'(1);
              end
              io_free = 1'b1;
            end else begin
              cur_io[sidx] <= f_cur_io - 4'd1;
            end
          end else begin
            io_free = 1'b1;
          end
          if (io_free) begin
            if (wcount != '0) begin
              io_slot_r  <= waiting_ring[whead];
              io_valid_r <= 1'b1;
              whead      <= w_next;
              wcount     <= wcount - POS_W'(1);
            end else begin
              io_valid_r <= 1'b0;
            end
          end
          idx   <= '0;
          state <= S_WAIT_SCAN;
        end

        S_WAIT_SCAN: begin
          if (idx_in_ring) begin
            if (aging_enable && by_prio && f_age != AGE_SAT) begin
              age[sidx] <= f_age + 8'd1;
            end
            if (f_wt != SAT16) begin
              wt[sidx] <= f_wt + 16'd1;
            end
          end
          if (idx == POS_W'(n_run)) begin
            idx   <= '0;
            state <= S_SLOT_SCAN;
          end else begin
            idx <= idx + POS_W'(1);
          end
        end

        S_SLOT_SCAN: begin
          if (active) begin
            ta[sidx] <= ta_new;
            if (f_age > AGE_LIMIT) begin
              prio[sidx] <= (f_prio != 4'd0) ? (f_prio - 4'd1) : 4'd0;
              age[sidx]  <= 8'd0;
            end
          end
          idx <= idx + POS_W'(1);
          if (idx == POS_W'(n_run - CNT_W'(1))) begin
            if (active && run_time != SAT16) begin
              run_time <= run_time + 16'd1;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // totals over the slot pass
  assign acc_ctrl.clear = (state == S_IDLE);
  assign acc_ctrl.en    = (state == S_SLOT_SCAN);

  mpts_acc u_acc (
    .clk  (clk),
    .ctrl (acc_ctrl),
    .ta   (ta_new),
    .arr  (s_arr[sidx]),
    .wt   (f_wt),
    .tsum (tsum),
    .wsum (wsum)
  );

  // result register: load when empty or being drained
  assign out_load = (state == S_DONE) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the totals here too: the accumulator clears as soon as the block idles
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_tick  <= tick_stamp;
      o_run_v <= ran_valid;
      o_run_s <= ran_valid ? ran_slot : 4'd0;
      o_io_v  <= io_valid_r;
      o_io_s  <= io_valid_r ? io_slot_r : 4'd0;
      o_fin   <= 5'(fin_count);
      o_done  <= (fin_count == n_run);
      o_idle  <= idle_total;
      o_tsum  <= tsum;
      o_wsum  <= wsum;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.tick_time        = o_tick;
  assign out_ch.running_valid    = o_run_v;
  assign out_ch.running_slot     = o_run_s;
  assign out_ch.io_valid         = o_io_v;
  assign out_ch.io_slot          = o_io_s;
  assign out_ch.finished_count   = o_fin;
  assign out_ch.all_done         = o_done;
  assign out_ch.total_turnaround = o_tsum;
  assign out_ch.total_wait       = o_wsum;
  assign out_ch.idle_ticks       = o_idle;

endmodule

`default_nettype wire
